[hw/rtl/cfp_pkg.sv]
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types and constants of the camera frame parser with silence timeout.
// ----------------------------------------------------------------------------
package cfp_pkg;

  // default frame buffer size, valid range 16 to 64
  localparam int FRAME_BYTES_DEF = 20;

  // only the first bytes of a frame are ever decoded into fields
  localparam int STORE_BYTES = 16;

  localparam logic [7:0]  HDR_BYTE       = 8'hAA;
  localparam logic [7:0]  ADDR_BYTE      = 8'h05;
  localparam logic [7:0]  KIND_BLOB_BYTE = 8'h41;
  localparam logic [7:0]  KIND_LINE_BYTE = 8'h42;
  localparam logic [15:0] LIMIT_RESET    = 16'd1000;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // frame kind and mode codes
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_BLOB = 2'd1;
  localparam logic [1:0] KIND_LINE = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
    logic [7:0] tick_ms;
  } cfp_item_t;

  typedef struct packed {
    logic [1:0]         frame_kind;
    logic [1:0]         mode;
    logic               offline;
    logic [7:0]         blob_flag;
    logic [7:0]         status;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] angle;
    logic signed [15:0] deviation;
    logic [7:0]         point_flag;
    logic [7:0]         frame_period_ms;
  } cfp_result_t;

endpackage

[hw/rtl/cfp_core.sv]
// ----------------------------------------------------------------------------
// cfp_core
// Parser state, frame byte store and silence counter; one request per step.
// ----------------------------------------------------------------------------
module cfp_core #(
  parameter int FRAME_BYTES = cfp_pkg::FRAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  cfp_pkg::cfp_item_t  item,
  input  logic [15:0]         limit,
  output cfp_pkg::cfp_result_t res
);

  localparam int POS_W  = $clog2(FRAME_BYTES);
  localparam int SIDX_W = $clog2(cfp_pkg::STORE_BYTES);
  localparam logic [7:0] MAX_LEN = 8'(FRAME_BYTES - 6);

  localparam logic [POS_W-1:0] P_HDR  = '0;
  localparam logic [POS_W-1:0] P_ANY  = POS_W'(1);
  localparam logic [POS_W-1:0] P_ADDR = POS_W'(2);
  localparam logic [POS_W-1:0] P_KIND = POS_W'(3);
  localparam logic [POS_W-1:0] P_LEN  = POS_W'(4);
  localparam logic [POS_W-1:0] P_PAY  = POS_W'(5);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [15:0]      cnt_r, cnt_nxt;
  logic             offline_r, offline_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic [7:0]       store_r [cfp_pkg::STORE_BYTES];
  logic [7:0]       view    [cfp_pkg::STORE_BYTES];

  logic [7:0]  b;
  logic [7:0]  pos_ext;
  logic        is_byte;
  logic        in_store;
  logic [16:0] tick_sum;
  logic [1:0]  kind;

  assign b        = item.data_byte;
  assign is_byte  = (item.cmd == cfp_pkg::CMD_BYTE);
  assign pos_ext  = 8'(pos_r);
  assign in_store = (pos_ext < 8'(cfp_pkg::STORE_BYTES));
  assign tick_sum = {1'b0, cnt_r} + 17'(item.tick_ms);

  // store contents as seen after this byte is written
  always_comb begin
    for (int i = 0; i < cfp_pkg::STORE_BYTES; i++) begin
      view[i] = store_r[i];
      if (is_byte && in_store && (pos_r[SIDX_W-1:0] == SIDX_W'(i))) begin
        view[i] = b;
      end
    end
  end

  always_comb begin
    pos_nxt     = pos_r;
    len_nxt     = len_r;
    sum_nxt     = sum_r;
    cnt_nxt     = cnt_r;
    offline_nxt = offline_r;
    mode_nxt    = mode_r;
    kind        = cfp_pkg::KIND_NONE;
    if (is_byte) begin
      priority if (pos_r == P_HDR) begin
        if (b == cfp_pkg::HDR_BYTE) begin
          sum_nxt = b;
          pos_nxt = P_ANY;
        end
      end else if (pos_r == P_ANY) begin
        sum_nxt = sum_r + b;
        pos_nxt = P_ADDR;
      end else if (pos_r == P_ADDR) begin
        sum_nxt = sum_r + b;
        pos_nxt = (b == cfp_pkg::ADDR_BYTE) ? P_KIND : P_HDR;
      end else if (pos_r == P_KIND) begin
        sum_nxt = sum_r + b;
        pos_nxt = (b == cfp_pkg::KIND_BLOB_BYTE || b == cfp_pkg::KIND_LINE_BYTE) ?
                  P_LEN : P_HDR;
      end else if (pos_r == P_LEN) begin
        len_nxt = b;
        sum_nxt = sum_r + b;
        pos_nxt = (b <= MAX_LEN) ? P_PAY : P_HDR;
      end else if (pos_ext == len_r + 8'd5) begin
        // checksum byte closes the frame either way
        if (sum_r == b) begin
          kind        = (view[3] == cfp_pkg::KIND_BLOB_BYTE) ?
                        cfp_pkg::KIND_BLOB : cfp_pkg::KIND_LINE;
          mode_nxt    = kind;
          cnt_nxt     = '0;
          offline_nxt = 1'b0;
        end
        pos_nxt = P_HDR;
      end else begin
        sum_nxt = sum_r + b;
        pos_nxt = pos_r + P_ANY;
      end
    end else begin
      if (cnt_r < limit) begin
        cnt_nxt = tick_sum[16] ? 16'hFFFF : tick_sum[15:0];
      end else begin
        offline_nxt = 1'b1;
        mode_nxt    = cfp_pkg::KIND_NONE;
      end
    end
  end

  always_comb begin
    res            = '0;
    res.frame_kind = kind;
    res.mode       = mode_nxt;
    res.offline    = offline_nxt;
    unique case (kind)
      cfp_pkg::KIND_BLOB: begin
        res.blob_flag       = view[5];
        res.status          = view[6];
        res.pos_x           = {view[7], view[8]};
        res.pos_y           = {view[9], view[10]};
        res.frame_period_ms = view[11];
      end
      cfp_pkg::KIND_LINE: begin
        res.status          = view[5];
        res.angle           = {view[6], view[7]};
        res.deviation       = {view[8], view[9]};
        res.point_flag      = view[10];
        res.pos_x           = {view[11], view[12]};
        res.pos_y           = {view[13], view[14]};
        res.frame_period_ms = view[15];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      len_r     <= '0;
      sum_r     <= '0;
      cnt_r     <= '0;
      offline_r <= 1'b0;
      mode_r    <= cfp_pkg::KIND_NONE;
      for (int i = 0; i < cfp_pkg::STORE_BYTES; i++) begin
        store_r[i] <= '0;
      end
    end else if (step_en) begin
      pos_r     <= pos_nxt;
      len_r     <= len_nxt;
      sum_r     <= sum_nxt;
      cnt_r     <= cnt_nxt;
      offline_r <= offline_nxt;
      mode_r    <= mode_nxt;
      for (int i = 0; i < cfp_pkg::STORE_BYTES; i++) begin
        store_r[i] <= view[i];
      end
    end
  end

endmodule

[hw/rtl/camera_frame_parser_with_timeout_top.sv]
// ----------------------------------------------------------------------------
// camera_frame_parser_with_timeout_top
// Serial camera frame parser with checksum check and silence timeout.
// ----------------------------------------------------------------------------
// Each input request is either a received byte (in_cmd low, in_data_byte) or
// a time tick (in_cmd high, in_tick_ms). Every request yields exactly one
// result: the kind of frame completed by it (if any), the current mode and
// offline flag, and the decoded fields of a good frame.
// Requests pass an input register, then one step of the parser logic into
// the result register, which drives out_valid. One request per cycle is
// taken while out_stall does not hold a result; the parser state is
// updated in a single step per request, which is what sets that rate.
// When out_stall holds a result, one more request can still be taken into
// the input register; after that in_stall rises until the result drains.
// cfg_wr_en writes the silence limit in ms; write it only while idle.
// Reset clears the parser, the byte store, the silence counter, the mode
// and offline flag, and sets the limit to 1000 ms.
// ----------------------------------------------------------------------------
module camera_frame_parser_with_timeout_top #(
  parameter int FRAME_BYTES = cfp_pkg::FRAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic [7:0]         in_data_byte,
  input  logic [7:0]         in_tick_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_frame_kind,
  output logic [1:0]         out_mode,
  output logic               out_offline,
  output logic [7:0]         out_blob_flag,
  output logic [7:0]         out_status,
  output logic signed [15:0] out_pos_x,
  output logic signed [15:0] out_pos_y,
  output logic signed [15:0] out_angle,
  output logic signed [15:0] out_deviation,
  output logic [7:0]         out_point_flag,
  output logic [7:0]         out_frame_period_ms
);

  logic                 s1_valid_r, s1_valid_nxt;
  cfp_pkg::cfp_item_t   s1_item_r;
  logic                 out_valid_r, out_valid_nxt;
  cfp_pkg::cfp_result_t out_res_r;
  cfp_pkg::cfp_result_t step_res;
  logic [15:0]          limit_r;
  logic                 out_adv;
  logic                 s1_adv;
  logic                 in_acc;

  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_adv;
  assign in_stall = s1_valid_r && !out_adv;
  assign in_acc   = in_valid && !in_stall;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_adv ? 1'b0 : out_valid_r);

  cfp_core #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(s1_adv),
    .item   (s1_item_r),
    .limit  (limit_r),
    .res    (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      limit_r     <= cfp_pkg::LIMIT_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.cmd       <= in_cmd;
      s1_item_r.data_byte <= in_data_byte;
      s1_item_r.tick_ms   <= in_tick_ms;
    end
    if (s1_adv) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_frame_kind      = out_res_r.frame_kind;
  assign out_mode            = out_res_r.mode;
  assign out_offline         = out_res_r.offline;
  assign out_blob_flag       = out_res_r.blob_flag;
  assign out_status          = out_res_r.status;
  assign out_pos_x           = out_res_r.pos_x;
  assign out_pos_y           = out_res_r.pos_y;
  assign out_angle           = out_res_r.angle;
  assign out_deviation       = out_res_r.deviation;
  assign out_point_flag      = out_res_r.point_flag;
  assign out_frame_period_ms = out_res_r.frame_period_ms;

  // a good frame sets the mode to its kind and clears offline
  a_frame_sets_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_kind != cfp_pkg::KIND_NONE |->
      out_mode == out_frame_kind && !out_offline)
    else $error("frame result with wrong mode or offline flag");

  // offline always goes together with no mode
  a_offline_no_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_offline |-> out_mode == cfp_pkg::KIND_NONE)
    else $error("offline result with a mode set");

  // a frame can only be completed by a received byte
  a_frame_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && step_res.frame_kind != cfp_pkg::KIND_NONE |->
      s1_item_r.cmd == cfp_pkg::CMD_BYTE)
    else $error("frame completed by a tick");

endmodule
